[rtl/core/afd_pkg.sv]
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants of the frame deframer.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int unsigned FRAME_LEN  = 17;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
  localparam logic [COUNT_W-1:0] IDX_HEADER  = 5'd0;
  localparam logic [COUNT_W-1:0] IDX_ADDRESS = 5'd1;
  localparam logic [COUNT_W-1:0] IDX_LENGTH  = 5'd2;
  localparam logic [COUNT_W-1:0] IDX_YAW_LO  = 5'd3;
  localparam logic [COUNT_W-1:0] IDX_YAW_HI  = 5'd6;
  localparam logic [COUNT_W-1:0] IDX_PIT_LO  = 5'd7;
  localparam logic [COUNT_W-1:0] IDX_PIT_HI  = 5'd10;
  localparam logic [COUNT_W-1:0] IDX_DEP_LO  = 5'd11;
  localparam logic [COUNT_W-1:0] IDX_DEP_HI  = 5'd14;
  localparam logic [COUNT_W-1:0] IDX_FLAGS   = 5'd15;
  localparam logic [COUNT_W-1:0] IDX_SUM     = COUNT_W'(FRAME_LEN - 1);
  localparam logic [7:0]         LEN_BYTE    = 8'(FRAME_LEN);

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 8'd1;

  localparam logic [7:0] HEADER_RESET  = 8'h42;
  localparam logic [7:0] ADDRESS_RESET = 8'h00;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_LENGTH   = 2'd1;
  localparam logic [1:0] STATUS_PREFIX   = 2'd2;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd3;

  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] yaw_bits;
    logic [31:0] pitch_bits;
    logic [31:0] depth_bits;
    logic [7:0]  control_flags;
    logic [7:0]  received_sum;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] address_value;
  } cfg_regs_t;

endpackage

[rtl/core/afd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// afd_cfg_regs
// Configuration register file: expected header and address bytes.
// ----------------------------------------------------------------------------
module afd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [afd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data,
  output afd_pkg::cfg_regs_t              regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.header_value  <= afd_pkg::HEADER_RESET;
      regs.address_value <= afd_pkg::ADDRESS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        afd_pkg::REG_HEADER:  regs.header_value  <= cfg_data;
        afd_pkg::REG_ADDRESS: regs.address_value <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/afd_frame_parser.sv]
// ----------------------------------------------------------------------------
// afd_frame_parser
// Per-byte frame state, field capture and end-of-frame status check.
// ----------------------------------------------------------------------------
module afd_frame_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat_valid,
  input  afd_pkg::in_beat_t   beat,
  input  afd_pkg::cfg_regs_t  regs,
  output logic                res_valid,
  output afd_pkg::out_beat_t  res
);

  logic [afd_pkg::COUNT_W-1:0] byte_count;
  logic [7:0]                  running_sum;
  logic                        prefix_bad;
  logic [31:0]                 yaw_shift;
  logic [31:0]                 pitch_shift;
  logic [31:0]                 depth_shift;
  logic [7:0]                  flag_hold;

  logic       prefix_hit;
  logic       bad_next;
  logic [1:0] status;

  always_comb begin
    prefix_hit = ((byte_count == afd_pkg::IDX_HEADER)  && (beat.data_byte != regs.header_value))
              || ((byte_count == afd_pkg::IDX_ADDRESS) && (beat.data_byte != regs.address_value))
              || ((byte_count == afd_pkg::IDX_LENGTH)  && (beat.data_byte != afd_pkg::LEN_BYTE));
    bad_next = prefix_bad | prefix_hit;
    if (byte_count != afd_pkg::IDX_SUM) begin
      status = afd_pkg::STATUS_LENGTH;
    end else if (bad_next) begin
      status = afd_pkg::STATUS_PREFIX;
    end else if (running_sum != beat.data_byte) begin
      status = afd_pkg::STATUS_CHECKSUM;
    end else begin
      status = afd_pkg::STATUS_OK;
    end
  end

  always_comb begin
    res_valid = beat_valid && beat.last_byte;
    res       = '0;
    res.status = status;
    if (status == afd_pkg::STATUS_OK) begin
      res.yaw_bits      = yaw_shift;
      res.pitch_bits    = pitch_shift ^ afd_pkg::SIGN_MASK;
      res.depth_bits    = depth_shift;
      res.control_flags = flag_hold;
      res.received_sum  = beat.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      prefix_bad  <= 1'b0;
    end else if (beat_valid) begin
      if (beat.last_byte) begin
        byte_count  <= '0;
        running_sum <= '0;
        prefix_bad  <= 1'b0;
      end else begin
        running_sum <= running_sum + beat.data_byte;
        prefix_bad  <= bad_next;
        if (byte_count != afd_pkg::COUNT_MAX) begin
          byte_count <= byte_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat_valid && !beat.last_byte) begin
      if (byte_count >= afd_pkg::IDX_YAW_LO && byte_count <= afd_pkg::IDX_YAW_HI) begin
        yaw_shift <= {beat.data_byte, yaw_shift[31:8]};
      end else if (byte_count >= afd_pkg::IDX_PIT_LO && byte_count <= afd_pkg::IDX_PIT_HI) begin
        pitch_shift <= {beat.data_byte, pitch_shift[31:8]};
      end else if (byte_count >= afd_pkg::IDX_DEP_LO && byte_count <= afd_pkg::IDX_DEP_HI) begin
        depth_shift <= {beat.data_byte, depth_shift[31:8]};
      end else if (byte_count == afd_pkg::IDX_FLAGS) begin
        flag_hold <= beat.data_byte;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (beat_valid && beat.last_byte) |=> (byte_count == '0 && running_sum == '0 && !prefix_bad))
    else $error("frame state not cleared after last beat");

  a_ok_needs_full_frame: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == afd_pkg::STATUS_OK) |->
      (byte_count == afd_pkg::IDX_SUM && !prefix_bad))
    else $error("ok status on short frame or bad prefix");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    (beat_valid && !beat.last_byte && byte_count != afd_pkg::COUNT_MAX) |=>
      (byte_count == $past(byte_count) + 1'b1))
    else $error("byte count did not advance");

endmodule

[rtl/core/afd_out_reg.sv]
// ----------------------------------------------------------------------------
// afd_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module afd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  afd_pkg::out_beat_t  load_data,
  output logic                out_valid,
  input  logic                out_ready,
  output afd_pkg::out_beat_t  out_data
);

  logic out_valid_next;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load)
    else $error("result overwritten while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && out_data == $past(load_data)))
    else $error("loaded result not presented");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

[rtl/core/aim_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// aim_frame_deframer_unit
// Fixed-length frame parser with additive checksum, one byte per beat.
//
// Input channel (in_valid/in_ready/in_data) takes one frame byte per beat,
// with last_byte set on the final byte. Output channel (out_valid/out_ready/
// out_data) gives one result beat per frame, carrying the status code and,
// on good frames, yaw, pitch (sign inverted), depth, flags and checksum.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// expected header (index 0) and address (index 1); other indexes are
// ignored. cfg_ready is always high.
// One byte per cycle while in_ready holds. The result beat appears the
// cycle after the last byte is accepted, from a single result register.
// When the receiver stalls, non-final bytes are still taken; a final byte
// waits until the held result is taken or is being taken that cycle.
// Reset clears the frame state and the result valid flag and restores the
// header to 0x42 and the address to 0.
// ----------------------------------------------------------------------------
module aim_frame_deframer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  afd_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output afd_pkg::out_beat_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);

  afd_pkg::cfg_regs_t  regs;
  afd_pkg::out_beat_t  res;
  logic                res_valid;
  logic                beat_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !in_data.last_byte || !out_valid || out_ready;
  assign beat_take = in_valid && in_ready;

  afd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  afd_frame_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_take),
    .beat       (in_data),
    .regs       (regs),
    .res_valid  (res_valid),
    .res        (res)
  );

  afd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[bench/aim_frame_deframer_unit_tb.sv]
// ----------------------------------------------------------------------------
// aim_frame_deframer_unit_tb
// Self-checking bench for the fixed-length frame deframer. A table of
// directed frames covers field extremes, each fault code and its priority,
// and short, long and saturating lengths. Register writes follow, including
// ignored indexes, and then random frames. Most are well formed with random
// payload, and the rest are faulty or pure noise. Both channels get random
// gaps, and one long receiver hold-off fills the block. Every result beat
// is checked field by field against a bench-side model of the parser.
// ----------------------------------------------------------------------------
module aim_frame_deframer_unit_tb;

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND, FILL_NOISE} fill_e;

  localparam logic [2:0] FLT_NONE = 3'b000;
  localparam logic [2:0] FLT_HDR  = 3'b001;
  localparam logic [2:0] FLT_ADDR = 3'b010;
  localparam logic [2:0] FLT_LEN  = 3'b100;

  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 250;

  typedef struct packed {
    logic [5:0] nbytes;
    logic [2:0] faults;
    logic       bad_sum;
    fill_e      fill;
    logic       pinned;
    logic [1:0] pin_status;
  } frame_row_t;

  frame_row_t dir_rows [0:13] = '{
    '{6'd17, FLT_NONE,          1'b0, FILL_ZERO, 1'b0, afd_pkg::STATUS_OK},
    '{6'd17, FLT_NONE,          1'b0, FILL_ONES, 1'b0, afd_pkg::STATUS_OK},
    '{6'd17, FLT_NONE,          1'b0, FILL_RAND, 1'b0, afd_pkg::STATUS_OK},
    '{6'd1,  FLT_NONE,          1'b0, FILL_RAND, 1'b1, afd_pkg::STATUS_LENGTH},
    '{6'd16, FLT_NONE,          1'b0, FILL_RAND, 1'b1, afd_pkg::STATUS_LENGTH},
    '{6'd18, FLT_NONE,          1'b0, FILL_RAND, 1'b1, afd_pkg::STATUS_LENGTH},
    '{6'd49, FLT_NONE,          1'b0, FILL_ONES, 1'b1, afd_pkg::STATUS_LENGTH},
    '{6'd17, FLT_HDR,           1'b0, FILL_RAND, 1'b1, afd_pkg::STATUS_PREFIX},
    '{6'd17, FLT_ADDR,          1'b0, FILL_RAND, 1'b1, afd_pkg::STATUS_PREFIX},
    '{6'd17, FLT_LEN,           1'b0, FILL_RAND, 1'b1, afd_pkg::STATUS_PREFIX},
    '{6'd17, FLT_NONE,          1'b1, FILL_RAND, 1'b1, afd_pkg::STATUS_CHECKSUM},
    '{6'd17, FLT_HDR | FLT_LEN, 1'b1, FILL_RAND, 1'b1, afd_pkg::STATUS_PREFIX},
    '{6'd16, FLT_ADDR,          1'b1, FILL_RAND, 1'b1, afd_pkg::STATUS_LENGTH},
    '{6'd17, FLT_NONE,          1'b0, FILL_RAND, 1'b0, afd_pkg::STATUS_OK}
  };

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  afd_pkg::in_beat_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  afd_pkg::out_beat_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [afd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                    cfg_data  = '0;

  always #2 clk = ~clk;

  aim_frame_deframer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [7:0]                  cur_header  = afd_pkg::HEADER_RESET;
  logic [7:0]                  cur_address = afd_pkg::ADDRESS_RESET;
  logic [afd_pkg::COUNT_W-1:0] fr_count    = '0;
  logic [7:0]                  fr_sum      = '0;
  logic                        fr_bad      = 1'b0;
  logic [31:0]                 fr_yaw      = '0;
  logic [31:0]                 fr_pitch    = '0;
  logic [31:0]                 fr_depth    = '0;
  logic [7:0]                  fr_flags    = '0;

  afd_pkg::out_beat_t pending_results [$];
  logic [7:0]         frame_bytes [$];
  afd_pkg::out_beat_t got_beat;
  afd_pkg::out_beat_t want_beat;
  int unsigned        fail_count = 0;
  int unsigned        bytes_sent = 0;
  bit                 tx_gaps    = 1'b1;
  bit                 rx_gaps    = 1'b1;
  bit                 hold_req   = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                    output afd_pkg::out_beat_t res);
    logic [afd_pkg::COUNT_W-1:0] pos;
    pos = fr_count;
    res = '0;
    if ((pos == afd_pkg::IDX_HEADER && b != cur_header) ||
        (pos == afd_pkg::IDX_ADDRESS && b != cur_address) ||
        (pos == afd_pkg::IDX_LENGTH && b != afd_pkg::LEN_BYTE))
      fr_bad = 1'b1;
    if (!fin) begin
      if (pos >= afd_pkg::IDX_YAW_LO && pos <= afd_pkg::IDX_YAW_HI)
        fr_yaw = {b, fr_yaw[31:8]};
      else if (pos >= afd_pkg::IDX_PIT_LO && pos <= afd_pkg::IDX_PIT_HI)
        fr_pitch = {b, fr_pitch[31:8]};
      else if (pos >= afd_pkg::IDX_DEP_LO && pos <= afd_pkg::IDX_DEP_HI)
        fr_depth = {b, fr_depth[31:8]};
      else if (pos == afd_pkg::IDX_FLAGS) fr_flags = b;
      fr_sum = fr_sum + b;
      if (fr_count != afd_pkg::COUNT_MAX) fr_count = fr_count + 1'b1;
      return 1'b0;
    end
    if (pos != afd_pkg::IDX_SUM) res.status = afd_pkg::STATUS_LENGTH;
    else if (fr_bad) res.status = afd_pkg::STATUS_PREFIX;
    else if (fr_sum != b) res.status = afd_pkg::STATUS_CHECKSUM;
    else begin
      res.status        = afd_pkg::STATUS_OK;
      res.yaw_bits      = fr_yaw;
      res.pitch_bits    = fr_pitch ^ afd_pkg::SIGN_MASK;
      res.depth_bits    = fr_depth;
      res.control_flags = fr_flags;
      res.received_sum  = b;
    end
    fr_count = '0;
    fr_sum   = '0;
    fr_bad   = 1'b0;
    fr_yaw   = '0;
    fr_pitch = '0;
    fr_depth = '0;
    fr_flags = '0;
    return 1'b1;
  endfunction

  function automatic void build_frame(input int unsigned len, input logic [2:0] faults,
                                      input logic bad_sum, input fill_e fill);
    logic [7:0] b;
    logic [7:0] sum;
    frame_bytes.delete();
    sum = '0;
    for (int unsigned i = 0; i + 1 < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      if (fill != FILL_NOISE) begin
        if (i == afd_pkg::IDX_HEADER)
          b = (faults & FLT_HDR) != 0 ? cur_header ^ 8'($urandom_range(1, 255)) : cur_header;
        else if (i == afd_pkg::IDX_ADDRESS)
          b = (faults & FLT_ADDR) != 0 ? cur_address ^ 8'($urandom_range(1, 255)) : cur_address;
        else if (i == afd_pkg::IDX_LENGTH)
          b = (faults & FLT_LEN) != 0 ? afd_pkg::LEN_BYTE ^ 8'($urandom_range(1, 255))
                                      : afd_pkg::LEN_BYTE;
      end
      frame_bytes.push_back(b);
      sum = sum + b;
    end
    if (fill == FILL_NOISE) frame_bytes.push_back(8'($urandom_range(0, 255)));
    else frame_bytes.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endfunction

  task automatic send_frame(input logic pinned, input logic [1:0] pin_status);
    int unsigned        g;
    logic               fin;
    afd_pkg::out_beat_t res;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (tx_gaps) begin
        g = pick_gap();
        if (g != 0) begin
          in_valid <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      fin = (i == frame_bytes.size() - 1);
      in_valid <= 1'b1;
      in_data  <= '{data_byte: frame_bytes[i], last_byte: fin};
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      bytes_sent++;
      if (parse_byte(frame_bytes[i], fin, res)) begin
        if (pinned) begin
          res        = '0;
          res.status = pin_status;
        end
        pending_results.push_back(res);
      end
    end
  endtask

  task automatic write_reg(input logic [afd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == afd_pkg::REG_HEADER) cur_header = val;
    else if (idx == afd_pkg::REG_ADDRESS) cur_address = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_beat = out_data;
      if (pending_results.size() == 0) begin
        $error("result beat with none expected: status %0d", got_beat.status);
        fail_count++;
      end else begin
        want_beat = pending_results.pop_front();
        check_field("status", 32'(want_beat.status), 32'(got_beat.status));
        check_field("yaw_bits", want_beat.yaw_bits, got_beat.yaw_bits);
        check_field("pitch_bits", want_beat.pitch_bits, got_beat.pitch_bits);
        check_field("depth_bits", want_beat.depth_bits, got_beat.depth_bits);
        check_field("control_flags", 32'(want_beat.control_flags),
                    32'(got_beat.control_flags));
        check_field("received_sum", 32'(want_beat.received_sum),
                    32'(got_beat.received_sum));
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_gaps = ~rx_gaps;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned frames;
    int unsigned r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i]) begin
      build_frame(dir_rows[i].nbytes, dir_rows[i].faults, dir_rows[i].bad_sum, dir_rows[i].fill);
      send_frame(dir_rows[i].pinned, dir_rows[i].pin_status);
    end

    settle();
    write_reg(afd_pkg::REG_HEADER, 8'h00);
    write_reg(afd_pkg::REG_ADDRESS, 8'hFF);
    build_frame(17, FLT_NONE, 1'b0, FILL_RAND);
    send_frame(1'b0, afd_pkg::STATUS_OK);
    build_frame(17, FLT_NONE, 1'b0, FILL_ZERO);
    send_frame(1'b0, afd_pkg::STATUS_OK);
    settle();
    write_reg(afd_pkg::REG_ADDRESS + 1'b1, 8'($urandom_range(0, 255)));
    write_reg({afd_pkg::CFG_IDX_W{1'b1}}, 8'($urandom_range(0, 255)));
    build_frame(17, FLT_NONE, 1'b0, FILL_ONES);
    send_frame(1'b0, afd_pkg::STATUS_OK);
    settle();
    write_reg(afd_pkg::REG_HEADER, 8'hFF);
    write_reg(afd_pkg::REG_ADDRESS, 8'h00);
    build_frame(17, FLT_NONE, 1'b0, FILL_ONES);
    send_frame(1'b0, afd_pkg::STATUS_OK);
    build_frame(17, FLT_ADDR, 1'b0, FILL_ONES);
    send_frame(1'b0, afd_pkg::STATUS_OK);

    frames = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (frames % 25 == 24) begin
        settle();
        write_reg(afd_pkg::REG_HEADER, pick_reg_value());
        write_reg(afd_pkg::REG_ADDRESS, pick_reg_value());
        if ($urandom_range(0, 2) == 0)
          write_reg(afd_pkg::CFG_IDX_W'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
      end
      if (frames == 30) hold_req = 1'b1;
      tx_gaps = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 70) build_frame(17, FLT_NONE, 1'b0, FILL_RAND);
      else if (r < 85)
        build_frame(17, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), FILL_RAND);
      else if (r < 93)
        build_frame($urandom_range(1, 49), FLT_NONE, 1'($urandom_range(0, 1)), FILL_RAND);
      else build_frame($urandom_range(1, 24), FLT_NONE, 1'b0, FILL_NOISE);
      send_frame(1'b0, afd_pkg::STATUS_OK);
      frames++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
